[rtl/core/qgram_filter_edit_distance_check_assert.svh]
// Assertion macros for the q-gram filter and edit distance check.
// Included by the checker module; depends on nothing else.
`ifndef QGRAM_FILTER_EDIT_DISTANCE_CHECK_ASSERT_SVH
`define QGRAM_FILTER_EDIT_DISTANCE_CHECK_ASSERT_SVH

// Consequence must hold in the cycle after the antecedent, outside reset.
`define QFED_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequence must hold in the same cycle as the antecedent, outside reset.
`define QFED_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checked at every edge, reset included.
`define QFED_ASSERT_ALWAYS(name, clk, ante, cons, msg) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/qfed_pkg.sv]
// Shared constants and types of the q-gram filter and edit distance check.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package qfed_pkg;

    // String geometry.
    localparam int STRING_LENGTH  = 15;
    localparam int GRAM_LENGTH    = 3;
    localparam int SYM_W          = 4;
    localparam int GRAM_POSITIONS = STRING_LENGTH - GRAM_LENGTH + 1;

    // Stream payload geometry, fixed by the field widths.
    localparam int IN_W         = 60;
    localparam int IN_SYMS      = IN_W / SYM_W;
    localparam int IN_TDATA_W   = 2 * IN_W;
    localparam int FIELD_W      = 4;
    localparam int FIELD_MAX    = 15;
    localparam int OUT_TDATA_W  = 16;

    // Internal widths.
    localparam int SCORE_W = $clog2(2 * STRING_LENGTH + 1);
    localparam int CNT_W   = $clog2(GRAM_POSITIONS + 1);
    localparam int EXT_W   = 8;

    // Configuration register indexes and reset values.
    localparam int                  CFG_IDX_W          = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAM_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 1'd1;
    localparam logic [FIELD_W-1:0]  RST_GRAM_THRESHOLD = 4'd4;
    localparam logic [FIELD_W-1:0]  RST_DISTANCE_LIMIT = 4'd3;

    typedef logic [SYM_W-1:0]                     t_sym;
    typedef logic [STRING_LENGTH-1:0][SYM_W-1:0]  t_syms;
    typedef logic [STRING_LENGTH-1:0]             t_vec;
    typedef logic [GRAM_POSITIONS-1:0]            t_hits;
    typedef logic [SCORE_W-1:0]                   t_score;

    // Item state carried down the pipeline.
    typedef struct packed {
        t_syms  q;
        t_syms  d;
        t_vec   vp;
        t_vec   vn;
        t_score score;
        t_hits  hits;
    } t_work;

    typedef struct packed {
        logic [FIELD_W-1:0] gram_threshold;
        logic [FIELD_W-1:0] distance_limit;
    } t_cfg;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic               is_match;
        logic [FIELD_W-1:0] edit_distance;
        logic               filter_pass;
        logic [FIELD_W-1:0] common_grams;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

[rtl/core/qfed_myers_col.sv]
// One column of the bit-parallel edit distance recurrence, as a pipeline stage.
// Depends on qfed_pkg.
`timescale 1ns / 1ps

module qfed_myers_col (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qfed_pkg::t_work i_work,
    output logic           o_valid,
    input  logic           i_ready,
    output qfed_pkg::t_work o_work
);
    import qfed_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;
    t_vec  eq, xv, sum, d0, hp, hn, hp_sh, hn_sh;

    // Match vector of the current database symbol against every query symbol.
    always_comb begin
        for (int i = 0; i < STRING_LENGTH; i++) begin
            eq[i] = (i_work.q[i] == i_work.d[0]);
        end
    end

    // Column update; the add wraps at the string length, which is the mask.
    always_comb begin
        xv    = eq | i_work.vn;
        sum   = (eq & i_work.vp) + i_work.vp;
        d0    = (sum ^ i_work.vp) | eq | i_work.vn;
        hp    = i_work.vn | ~(d0 | i_work.vp);
        hn    = i_work.vp & d0;
        hp_sh = {hp[STRING_LENGTH-2:0], 1'b1};
        hn_sh = {hn[STRING_LENGTH-2:0], 1'b0};

        n_work       = i_work;
        n_work.d     = i_work.d >> SYM_W;
        n_work.vp    = hn_sh | ~(xv | hp_sh);
        n_work.vn    = hp_sh & xv;
        n_work.score = i_work.score;
        // The two carries out of the top row never occur together.
        if (hp[STRING_LENGTH-1]) begin
            n_work.score = i_work.score + SCORE_W'(1);
        end else if (hn[STRING_LENGTH-1]) begin
            n_work.score = i_work.score - SCORE_W'(1);
        end
    end

    // Stage handshake: take a new item when empty or when the next stage takes ours.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

[rtl/core/qfed_gram_stage.sv]
// Entry stage: splits the strings into symbols, finds the shared grams and
// seeds the distance recurrence. Depends on qfed_pkg.
`timescale 1ns / 1ps

module qfed_gram_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [qfed_pkg::IN_W-1:0] i_query,
    input  logic [qfed_pkg::IN_W-1:0] i_db,
    output logic                      o_valid,
    input  logic                      i_ready,
    output qfed_pkg::t_work           o_work
);
    import qfed_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;
    t_syms q_syms, d_syms;
    t_hits hits;

    // Symbol positions that do not fit in the input word read as zero.
    for (genvar i = 0; i < STRING_LENGTH; i++) begin : g_sym
        if (i < IN_SYMS) begin : g_in
            assign q_syms[i] = i_query[i*SYM_W +: SYM_W];
            assign d_syms[i] = i_db[i*SYM_W +: SYM_W];
        end else begin : g_pad
            assign q_syms[i] = '0;
            assign d_syms[i] = '0;
        end
    end

    // A query gram hits when it equals the gram at any database position.
    for (genvar g = 0; g < GRAM_POSITIONS; g++) begin : g_gram
        t_vec found;
        for (genvar k = 0; k < GRAM_POSITIONS; k++) begin : g_pos
            assign found[k] = (q_syms[g +: GRAM_LENGTH] == d_syms[k +: GRAM_LENGTH]);
        end
        for (genvar k = GRAM_POSITIONS; k < STRING_LENGTH; k++) begin : g_none
            assign found[k] = 1'b0;
        end
        assign hits[g] = |found;
    end

    // Initial recurrence state: all vertical deltas positive, score at the length.
    always_comb begin
        n_work.q     = q_syms;
        n_work.d     = d_syms;
        n_work.vp    = '1;
        n_work.vn    = '0;
        n_work.score = SCORE_W'(STRING_LENGTH);
        n_work.hits  = hits;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

[rtl/core/qfed_out_stage.sv]
// Output register: counts the shared grams, applies both thresholds and
// saturates the reported fields. Depends on qfed_pkg.
`timescale 1ns / 1ps

module qfed_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  qfed_pkg::t_work   i_work,
    input  qfed_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output qfed_pkg::t_result o_result
);
    import qfed_pkg::*;

    logic             r_valid;
    t_result          r_result;
    t_result          n_result;
    logic [CNT_W-1:0] count;
    logic [EXT_W-1:0] count_x, dist_x;
    logic             pass;

    // Population count of the gram hit vector.
    always_comb begin
        count = '0;
        for (int g = 0; g < GRAM_POSITIONS; g++) begin
            count = count + CNT_W'(i_work.hits[g]);
        end
    end

    // Decisions use the full values; the fields saturate afterwards.
    always_comb begin
        count_x = EXT_W'(count);
        dist_x  = EXT_W'(i_work.score);
        pass    = (count_x >= EXT_W'(i_cfg.gram_threshold));

        n_result.common_grams  = (count_x > EXT_W'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX)
                                                               : count_x[FIELD_W-1:0];
        n_result.filter_pass   = pass;
        n_result.edit_distance = (dist_x > EXT_W'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX)
                                                              : dist_x[FIELD_W-1:0];
        n_result.is_match      = pass && (dist_x <= EXT_W'(i_cfg.distance_limit));
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/core/qgram_filter_edit_distance_check.sv]
// Pipeline: 17 register stages (gram stage, one stage per database symbol of the
// distance recurrence, output register), each with its own valid bit; a result is
// held in the output register until the sink takes it.
// Throughput: one item per cycle unless the sink stalls the pipeline.
// Reset (synchronous, active low) empties the pipeline and sets gram_threshold
// to 4 and distance_limit to 3. Depends on qfed_pkg and the stage modules.
`timescale 1ns / 1ps

module qgram_filter_edit_distance_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [qfed_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [qfed_pkg::FIELD_W-1:0]        i_cfg_data,
    // Input items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [qfed_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // query_symbols, db_symbols
    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [qfed_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // common_grams, filter_pass,
                                                                // edit_distance, is_match, zeros
);
    import qfed_pkg::*;

    logic [FIELD_W-1:0] r_gram_threshold;
    logic [FIELD_W-1:0] r_distance_limit;
    t_cfg               cfg;

    t_work   work  [STRING_LENGTH+1];
    logic    valid [STRING_LENGTH+1];
    logic    ready [STRING_LENGTH+2];
    t_result result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gram_threshold <= RST_GRAM_THRESHOLD;
            r_distance_limit <= RST_DISTANCE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRAM_THRESHOLD: r_gram_threshold <= i_cfg_data;
                CFG_DISTANCE_LIMIT: r_distance_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.gram_threshold = r_gram_threshold;
    assign cfg.distance_limit = r_distance_limit;

    // Entry stage.
    qfed_gram_stage u_gram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (ready[0]),
        .i_query (s_axis_tdata[IN_W-1:0]),
        .i_db    (s_axis_tdata[IN_TDATA_W-1:IN_W]),
        .o_valid (valid[0]),
        .i_ready (ready[1]),
        .o_work  (work[0])
    );

    assign s_axis_tready = ready[0];

    // One recurrence stage per database symbol.
    for (genvar j = 0; j < STRING_LENGTH; j++) begin : g_col
        qfed_myers_col u_col (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[j]),
            .o_ready (ready[j+1]),
            .i_work  (work[j]),
            .o_valid (valid[j+1]),
            .i_ready (ready[j+2]),
            .o_work  (work[j+1])
        );
    end

    // Output register.
    qfed_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (valid[STRING_LENGTH]),
        .o_ready  (ready[STRING_LENGTH+1]),
        .i_work   (work[STRING_LENGTH]),
        .i_cfg    (cfg),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

[rtl/core/qfed_checker.sv]
// Port-level checks of the q-gram filter and edit distance check, bound to the top.
// Depends on qfed_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "qgram_filter_edit_distance_check_assert.svh"

module qfed_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [qfed_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import qfed_pkg::*;

    // Bit positions of the two flags in the result item.
    localparam int PASS_BIT  = FIELD_W;
    localparam int MATCH_BIT = 2 * FIELD_W + 1;

    // A result waiting for the sink keeps its value.
    `QFED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result item changed while stalled")

    // With the sink ready, the whole pipeline moves and input is taken.
    `QFED_ASSERT_NOW(a_flow_through, i_clk, i_rst_n, m_axis_tready, s_axis_tready,
        "input stalled although the output side is ready")

    // A match needs the gram filter to pass.
    `QFED_ASSERT_NOW(a_match_pass, i_clk, i_rst_n, m_axis_tvalid,
        !(m_axis_tdata[MATCH_BIT] && !m_axis_tdata[PASS_BIT]),
        "match reported without filter pass")

    // Reset empties the pipeline.
    `QFED_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid,
        "result item shown right after reset")

endmodule

bind qgram_filter_edit_distance_check qfed_checker u_qfed_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
